// ----- rtl/sawc_pkg.sv -----
// types and codes shared by the stop-and-wait arq controller
`timescale 1ns / 1ps

package sawc_pkg;

	localparam int unsigned SEQ_W = 8;
	localparam int unsigned ID_W  = 8;

	// event codes carried on the input tuser
	localparam logic [2:0] EV_TO_SEND  = 3'd0;
	localparam logic [2:0] EV_RCVD     = 3'd1;
	localparam logic [2:0] EV_DTX_DONE = 3'd2;
	localparam logic [2:0] EV_ATX_DONE = 3'd3;
	localparam logic [2:0] EV_ACK      = 3'd4;
	localparam logic [2:0] EV_TIMEOUT  = 3'd5;

	localparam int unsigned NUM_EV = 6;

	// configuration register indexes
	localparam logic [7:0] REG_DEST_ID  = 8'd0;
	localparam logic [7:0] REG_MAX_RETX = 8'd1;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_TX   = 2'd1,
		FSM_ACK  = 2'd2
	} fsm_t;

	typedef enum logic [2:0] {
		ACT_HELD      = 3'd0,
		ACT_SEND_DATA = 3'd1,
		ACT_SEND_ACK  = 3'd2,
		ACT_RETX      = 3'd3,
		ACT_ACK_OK    = 3'd4,
		ACT_ACK_WRONG = 3'd5,
		ACT_GAVE_UP   = 3'd6,
		ACT_DISCARD   = 3'd7
	} action_t;

	typedef enum logic {
		SQ_WAIT  = 1'b0,
		SQ_SERVE = 1'b1
	} seq_state_t;

	typedef struct packed {
		action_t           action;
		logic [SEQ_W-1:0]  seq;
		logic [ID_W-1:0]   peer;
		logic              tstart;
		logic              tstop;
		fsm_t              fsm_after;
	} res_t;

endpackage

// ----- rtl/stop_and_wait_arq_controller.sv -----
// stop-and-wait arq controller: event intake, flag sequencer and result stream
//
// Usage: each beat on the s_axis channel carries one protocol event (tuser) with the
// sequence and source of a received frame (tdata). The event sets a pending flag; a small
// sequencer then runs the shared serve unit once per cycle, handling one pending flag per
// pass in the priority order of the current protocol state, and sends one result beat per
// handled flag on m_axis, the final one marked by tlast. An event that handles nothing
// gives one held result. The cfg channel writes dest_id (index 0) and max_retx (index 1);
// it is always ready and is meant to be written only while the block is idle.
// Timing: an event that handles n flags (0 to 6) holds s_axis_tready low until its last
// result is pushed to the output register, so no new event is taken while one is served;
// when m_axis is not stalled its results follow one per cycle. The sequencer keeps one
// result in a buffer so it knows which result is the last before it is sent.
// A stall on m_axis freezes the sequencer with its buffered result; the serve unit resumes
// when the output register is taken. Reset returns the protocol state to idle, clears all
// pending flags, counters and latched values, sets dest_id to 0 and max_retx to 3.
module stop_and_wait_arq_controller #(
	parameter int unsigned SEQ_MODULUS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // frame_seq[7:0], src_id[15:8]
	input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // seq_out[7:0], peer_id[15:8], timer_start[16],
	                                    // timer_stop[17], fsm_after[19:18], zero[23:20]
	output logic [2:0]  m_axis_tuser,   // action[2:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import sawc_pkg::*;

	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MODULUS - 1);

	// configuration
	logic [ID_W-1:0]   dest_id_q;
	logic [7:0]        max_retx_q;

	// protocol state
	fsm_t              fsm_q;
	logic [NUM_EV-1:0] pend_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [SEQ_W-1:0]  sent_seq_q;
	logic [7:0]        retry_q;
	logic              timer_run_q;
	logic [SEQ_W-1:0]  rx_seq_q;
	logic [ID_W-1:0]   rx_src_q;
	logic [SEQ_W-1:0]  ack_seq_q;

	// sequencer
	seq_state_t        sq_q;
	seq_state_t        sq_n;
	res_t              buf_q;
	logic              buf_vld_q;
	res_t              out_q;
	logic              out_vld_q;
	logic              out_last_q;

	// serve unit
	logic              hit;
	res_t              res;
	fsm_t              fsm_n;
	logic [NUM_EV-1:0] pend_n;
	logic [SEQ_W-1:0]  next_seq_n;
	logic [SEQ_W-1:0]  sent_seq_n;
	logic [7:0]        retry_n;
	logic              timer_run_n;

	// sequencer controls
	logic              in_acc;
	logic              out_free;
	logic              commit;
	logic              push;
	logic              done;
	res_t              push_res;
	res_t              held_res;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_vld_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_id_q  <= '0;
			max_retx_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEST_ID) begin
				dest_id_q <= cfg_data;
			end else if (cfg_index == REG_MAX_RETX) begin
				max_retx_q <= cfg_data;
			end
		end
	end

	// serve unit: handles the highest-priority pending flag of the current state
	always_comb begin
		hit         = 1'b0;
		res         = '0;
		res.action  = ACT_HELD;
		fsm_n       = fsm_q;
		pend_n      = pend_q;
		next_seq_n  = next_seq_q;
		sent_seq_n  = sent_seq_q;
		retry_n     = retry_q;
		timer_run_n = timer_run_q;
		case (fsm_q)
			FSM_IDLE: begin
				if (pend_q[EV_RCVD]) begin
					hit            = 1'b1;
					pend_n[EV_RCVD] = 1'b0;
					fsm_n          = FSM_TX;
					res.action     = ACT_SEND_ACK;
					res.seq        = rx_seq_q;
					res.peer       = rx_src_q;
				end else if (pend_q[EV_TO_SEND]) begin
					hit                = 1'b1;
					pend_n[EV_TO_SEND] = 1'b0;
					sent_seq_n         = next_seq_q;
					next_seq_n         = (next_seq_q == SEQ_LAST) ? '0 : next_seq_q + 1'b1;
					retry_n            = '0;
					fsm_n              = FSM_TX;
					res.action         = ACT_SEND_DATA;
					res.seq            = next_seq_q;
					res.peer           = dest_id_q;
				end else if (pend_q[EV_DTX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_DTX_DONE] = 1'b0;
					res.action          = ACT_DISCARD;
				end else if (pend_q[EV_ATX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_ATX_DONE] = 1'b0;
					res.action          = ACT_DISCARD;
				end else if (pend_q[EV_ACK]) begin
					hit            = 1'b1;
					pend_n[EV_ACK] = 1'b0;
					res.action     = ACT_DISCARD;
				end else if (pend_q[EV_TIMEOUT]) begin
					hit                = 1'b1;
					pend_n[EV_TIMEOUT] = 1'b0;
					res.action         = ACT_DISCARD;
				end
			end
			FSM_TX: begin
				if (pend_q[EV_ATX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_ATX_DONE] = 1'b0;
					fsm_n = (timer_run_q || pend_q[EV_TIMEOUT]) ? FSM_ACK : FSM_IDLE;
				end else if (pend_q[EV_DTX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_DTX_DONE] = 1'b0;
					timer_run_n         = 1'b1;
					fsm_n               = FSM_ACK;
					res.tstart          = 1'b1;
				end
			end
			FSM_ACK: begin
				if (pend_q[EV_ACK]) begin
					hit            = 1'b1;
					pend_n[EV_ACK] = 1'b0;
					if (ack_seq_q == sent_seq_q) begin
						timer_run_n = 1'b0;
						fsm_n       = FSM_IDLE;
						res.action  = ACT_ACK_OK;
						res.seq     = sent_seq_q;
						res.tstop   = 1'b1;
					end else begin
						res.action = ACT_ACK_WRONG;
						res.seq    = ack_seq_q;
					end
				end else if (pend_q[EV_TIMEOUT]) begin
					hit                = 1'b1;
					pend_n[EV_TIMEOUT] = 1'b0;
					res.seq            = sent_seq_q;
					if (retry_q >= max_retx_q) begin
						fsm_n      = FSM_IDLE;
						res.action = ACT_GAVE_UP;
					end else begin
						retry_n    = retry_q + 1'b1;
						fsm_n      = FSM_TX;
						res.action = ACT_RETX;
						res.peer   = dest_id_q;
					end
				end else if (pend_q[EV_RCVD]) begin
					hit             = 1'b1;
					pend_n[EV_RCVD] = 1'b0;
					fsm_n           = FSM_TX;
					res.action      = ACT_SEND_ACK;
					res.seq         = rx_seq_q;
					res.peer        = rx_src_q;
				end else if (pend_q[EV_DTX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_DTX_DONE] = 1'b0;
					res.action          = ACT_DISCARD;
				end else if (pend_q[EV_ATX_DONE]) begin
					hit                 = 1'b1;
					pend_n[EV_ATX_DONE] = 1'b0;
					res.action          = ACT_DISCARD;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		res.fsm_after = fsm_n;
	end

	// sequencer next state
	always_comb begin
		sq_n = sq_q;
		case (sq_q)
			SQ_WAIT: begin
				if (in_acc) begin
					sq_n = SQ_SERVE;
				end
			end
			SQ_SERVE: begin
				if (!hit && out_free) begin
					sq_n = SQ_WAIT;
				end
			end
			default: begin
				sq_n = SQ_WAIT;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		held_res           = '0;
		held_res.action    = ACT_HELD;
		held_res.fsm_after = fsm_q;
		s_axis_tready      = 1'b0;
		commit             = 1'b0;
		push               = 1'b0;
		done               = 1'b0;
		push_res           = buf_vld_q ? buf_q : held_res;
		case (sq_q)
			SQ_WAIT: begin
				s_axis_tready = 1'b1;
			end
			SQ_SERVE: begin
				commit = hit && (!buf_vld_q || out_free);
				push   = out_free && (!hit || buf_vld_q);
				done   = !hit && out_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q        <= SQ_WAIT;
			fsm_q       <= FSM_IDLE;
			pend_q      <= '0;
			next_seq_q  <= '0;
			sent_seq_q  <= '0;
			retry_q     <= '0;
			timer_run_q <= 1'b0;
			rx_seq_q    <= '0;
			rx_src_q    <= '0;
			ack_seq_q   <= '0;
			buf_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			sq_q <= sq_n;
			if (in_acc) begin
				case (s_axis_tuser)
					EV_RCVD: begin
						rx_seq_q <= s_axis_tdata[7:0];
						rx_src_q <= s_axis_tdata[15:8];
					end
					EV_ACK: begin
						ack_seq_q <= s_axis_tdata[7:0];
					end
					EV_TIMEOUT: begin
						timer_run_q <= 1'b0;
					end
					default: begin
					end
				endcase
				if (s_axis_tuser <= EV_TIMEOUT) begin
					pend_q[s_axis_tuser] <= 1'b1;
				end
			end
			if (commit) begin
				fsm_q       <= fsm_n;
				pend_q      <= pend_n;
				next_seq_q  <= next_seq_n;
				sent_seq_q  <= sent_seq_n;
				retry_q     <= retry_n;
				timer_run_q <= timer_run_n;
				buf_vld_q   <= 1'b1;
			end else if (done) begin
				buf_vld_q <= 1'b0;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			buf_q <= res;
		end
		if (push) begin
			out_q      <= push_res;
			out_last_q <= !hit;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.action;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0000, out_q.fsm_after, out_q.tstop, out_q.tstart,
		out_q.peer, out_q.seq};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("accepted a new event while serving");

	a_buf_only_serving: assert property (@(posedge clk) disable iff (!arst_n)
		buf_vld_q |-> (sq_q == SQ_SERVE))
		else $error("result buffer valid outside the serve phase");

	a_discard_not_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_q.action == ACT_DISCARD)) |-> (out_q.fsm_after != FSM_TX))
		else $error("discard result left the protocol in transmitting");

	a_ack_ok_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_q.action == ACT_ACK_OK))
		|-> (out_q.tstop && (out_q.fsm_after == FSM_IDLE)))
		else $error("ack_ok without timer stop and return to idle");

endmodule
